@@ sv/moving_average_crossover_deadband_core_defines.svh @@
// Assertion macros for the moving average crossover core.
`ifndef MOVING_AVERAGE_CROSSOVER_DEADBAND_CORE_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_DEADBAND_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MACD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MACD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MACD_ASSERT_ALWAYS(lbl, expr, msg)
`define MACD_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

@@ sv/macd_pkg.sv @@
// Shared types and constants for the moving average crossover core.
`timescale 1ns / 1ps

package macd_pkg;

  localparam int PRICE_W    = 32;
  localparam int MAG_W      = PRICE_W - 1;
  localparam int MAX_WINDOW = 64;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W      = MAG_W + RING_AW;
  localparam int FAST_W     = 6;
  localparam int SLOW_W     = 7;
  localparam int DBAND_W    = 31;
  localparam int FS_W       = FAST_W + SLOW_W;
  localparam int BAND_W     = DBAND_W + FS_W;
  localparam int PROD_W     = SUM_W + SLOW_W;
  localparam int CMP_W      = ((PROD_W > BAND_W) ? PROD_W : BAND_W) + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DBAND_W;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd2;

  typedef enum logic [1:0] {
    DEC_HOLD = 2'd0,
    DEC_BUY  = 2'd1,
    DEC_SELL = 2'd2
  } decision_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] fast_sum;
    logic [SUM_W-1:0] slow_sum;
  } dec_req_t;

  typedef struct packed {
    logic      done;
    decision_t decision;
  } dec_rsp_t;

endpackage

@@ sv/macd_ring.sv @@
// Price ring memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module macd_ring (
  input  logic                        clk,
  input  logic                        we,
  input  logic [macd_pkg::RING_AW-1:0] waddr,
  input  logic [macd_pkg::MAG_W-1:0]   wdata,
  input  logic [macd_pkg::RING_AW-1:0] raddr,
  output logic [macd_pkg::MAG_W-1:0]   rdata
);
  import macd_pkg::*;

  logic [MAG_W-1:0] mem [MAX_WINDOW];
  logic [MAG_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/macd_decide.sv @@
// Cross-multiplied mean comparison with deadband, three register stages.
`timescale 1ns / 1ps

module macd_decide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [macd_pkg::FAST_W-1:0]  fast_len,
  input  logic [macd_pkg::SLOW_W-1:0]  slow_len,
  input  logic [macd_pkg::DBAND_W-1:0] deadband,
  input  macd_pkg::dec_req_t           req,
  output macd_pkg::dec_rsp_t           rsp
);
  import macd_pkg::*;

  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] lhs_r, lhs_nxt;
  logic [PROD_W-1:0] rhs_r, rhs_nxt;
  logic [FS_W-1:0]   fs_r, fs_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  decision_t         dec_r, dec_nxt;
  logic [CMP_W-1:0]  lhs_ext, rhs_ext, band_ext;

  always_comb begin
    v1_nxt   = req.start;
    v2_nxt   = v1_r;
    done_nxt = v2_r;
    lhs_nxt  = lhs_r;
    rhs_nxt  = rhs_r;
    fs_nxt   = fs_r;
    band_nxt = band_r;
    dec_nxt  = dec_r;
    lhs_ext  = CMP_W'(lhs_r);
    rhs_ext  = CMP_W'(rhs_r);
    band_ext = CMP_W'(band_r);

    // stage 1: scale each sum by the other window length
    if (req.start) begin
      lhs_nxt = PROD_W'(req.fast_sum) * PROD_W'(slow_len);
      rhs_nxt = PROD_W'(req.slow_sum) * PROD_W'(fast_len);
      fs_nxt  = FS_W'(fast_len) * FS_W'(slow_len);
    end
    // stage 2: deadband scaled by both lengths
    if (v1_r) begin
      band_nxt = BAND_W'(deadband) * BAND_W'(fs_r);
    end
    // stage 3: compare against the band on both sides
    if (v2_r) begin
      if (lhs_ext > rhs_ext + band_ext) begin
        dec_nxt = DEC_BUY;
      end else if (lhs_ext + band_ext < rhs_ext) begin
        dec_nxt = DEC_SELL;
      end else begin
        dec_nxt = DEC_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      done_r <= done_nxt;
    end
    lhs_r  <= lhs_nxt;
    rhs_r  <= rhs_nxt;
    fs_r   <= fs_nxt;
    band_r <= band_nxt;
    dec_r  <= dec_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.decision = dec_r;

endmodule

@@ sv/moving_average_crossover_deadband_core.sv @@
// Top level: dual moving average crossover with deadband over a price ring.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_price (32b signed)
//   out      output     out_valid/out_ready  out_decision (2b), out_config_error (1b)
//   cfg      input      cfg_we (no stall)    cfg_index (2b), cfg_wdata (31b)
//
// One transaction at a time; the ring read-modify-write and the decide unit set the pace.
// Bad lengths or a nonpositive price: the accept state goes straight to the result state.
// Window still filling: accept, two ring reads, one ring write, fill check, result.
// Full window: adds the multiply and compare of the decide unit before the result.
// Reset is synchronous and needs no clearing pass; a stalled result blocks the next
// result only, a new input is taken while it waits.
`timescale 1ns / 1ps
`include "moving_average_crossover_deadband_core_defines.svh"

module moving_average_crossover_deadband_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [macd_pkg::PRICE_W-1:0] in_price,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_decision,
  output logic                            out_config_error,
  input  logic                            cfg_we,
  input  logic [macd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [macd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import macd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDS,
    S_WR,
    S_EVAL,
    S_WAIT,
    S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [FAST_W-1:0]  fast_len_r, fast_len_nxt;
  logic [SLOW_W-1:0]  slow_len_r, slow_len_nxt;
  logic [DBAND_W-1:0] deadband_r, deadband_nxt;
  logic [RING_AW-1:0] slot_r, slot_nxt;
  logic [SLOW_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]   fast_sum_r, fast_sum_nxt;
  logic [SUM_W-1:0]   slow_sum_r, slow_sum_nxt;
  logic [MAG_W-1:0]   price_r, price_nxt;
  decision_t          res_dec_r, res_dec_nxt;
  logic               res_err_r, res_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  decision_t          out_decision_r, out_decision_nxt;
  logic               out_err_r, out_err_nxt;

  logic               in_accept;
  logic               bad_cfg;
  logic               nonpos;
  logic               ring_we;
  logic [RING_AW-1:0] ring_raddr;
  logic [MAG_W-1:0]   ring_rdata;
  dec_req_t           dec_req;
  dec_rsp_t           dec_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign bad_cfg   = (fast_len_r == '0) || (slow_len_r > SLOW_W'(MAX_WINDOW)) ||
                     (SLOW_W'(fast_len_r) >= slow_len_r);
  assign nonpos    = in_price[PRICE_W-1] || (in_price == '0);

  // fast tail is read at accept, slow tail on the following cycle
  assign ring_raddr = (state_r == S_IDLE) ? (slot_r - fast_len_r[RING_AW-1:0])
                                          : (slot_r - slow_len_r[RING_AW-1:0]);
  assign ring_we    = (state_r == S_WR);

  assign dec_req.start    = (state_r == S_EVAL) && (fill_r >= slow_len_r);
  assign dec_req.fast_sum = fast_sum_r;
  assign dec_req.slow_sum = slow_sum_r;

  macd_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (price_r),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  macd_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .fast_len (fast_len_r),
    .slow_len (slow_len_r),
    .deadband (deadband_r),
    .req      (dec_req),
    .rsp      (dec_rsp)
  );

  always_comb begin
    state_nxt        = state_r;
    fast_len_nxt     = fast_len_r;
    slow_len_nxt     = slow_len_r;
    deadband_nxt     = deadband_r;
    slot_nxt         = slot_r;
    fill_nxt         = fill_r;
    fast_sum_nxt     = fast_sum_r;
    slow_sum_nxt     = slow_sum_r;
    price_nxt        = price_r;
    res_dec_nxt      = res_dec_r;
    res_err_nxt      = res_err_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_decision_nxt = out_decision_r;
    out_err_nxt      = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          price_nxt   = in_price[MAG_W-1:0];
          res_dec_nxt = DEC_HOLD;
          res_err_nxt = bad_cfg;
          if (bad_cfg || nonpos) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RDS;
          end
        end
      end
      S_RDS: begin
        // drop the oldest fast price once the fast window is full
        fast_sum_nxt = fast_sum_r + SUM_W'(price_r) -
                       ((fill_r >= SLOW_W'(fast_len_r)) ? SUM_W'(ring_rdata) : '0);
        state_nxt    = S_WR;
      end
      S_WR: begin
        slow_sum_nxt = slow_sum_r + SUM_W'(price_r) -
                       ((fill_r >= slow_len_r) ? SUM_W'(ring_rdata) : '0);
        slot_nxt     = slot_r + 1'b1;
        if (fill_r < slow_len_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (fill_r >= slow_len_r) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WAIT: begin
        if (dec_rsp.done) begin
          res_dec_nxt = dec_rsp.decision;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_decision_nxt = res_dec_r;
          out_err_nxt      = res_err_r;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_FAST_LEN: begin
          fast_len_nxt = cfg_wdata[FAST_W-1:0];
          slot_nxt     = '0;
          fill_nxt     = '0;
          fast_sum_nxt = '0;
          slow_sum_nxt = '0;
        end
        REG_SLOW_LEN: begin
          slow_len_nxt = cfg_wdata[SLOW_W-1:0];
          slot_nxt     = '0;
          fill_nxt     = '0;
          fast_sum_nxt = '0;
          slow_sum_nxt = '0;
        end
        REG_DEADBAND: deadband_nxt = cfg_wdata[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fast_len_r  <= FAST_W'(2);
      slow_len_r  <= SLOW_W'(3);
      deadband_r  <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      fast_sum_r  <= '0;
      slow_sum_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fast_len_r  <= fast_len_nxt;
      slow_len_r  <= slow_len_nxt;
      deadband_r  <= deadband_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      fast_sum_r  <= fast_sum_nxt;
      slow_sum_r  <= slow_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    price_r        <= price_nxt;
    res_dec_r      <= res_dec_nxt;
    res_err_r      <= res_err_nxt;
    out_decision_r <= out_decision_nxt;
    out_err_r      <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_decision     = out_decision_r;
  assign out_config_error = out_err_r;

  `MACD_ASSERT_ALWAYS(a_fill_bounded, fill_r <= slow_len_r, "fill count exceeds slow length")
  `MACD_ASSERT_IMP(a_fast_le_slow, state_r == S_IDLE, fast_sum_r <= slow_sum_r, "fast sum too big")
  `MACD_ASSERT_IMP(a_err_holds, out_valid_r && out_err_r, out_decision_r == DEC_HOLD, "config error without hold")

endmodule

@@ tb/moving_average_crossover_deadband_core_tb.sv @@
// Self-checking testbench for the moving average crossover core with deadband.
`timescale 1ns / 1ps

module moving_average_crossover_deadband_core_tb;
  import macd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    decision_t decision;
    logic      config_error;
  } signal_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [PRICE_W-1:0]   in_price = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_decision;
  logic                        out_config_error;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata = '0;

  logic signed [PRICE_W-1:0] price_queue[$];
  signal_t                   expected_signals[$];
  int                        mismatch_count = 0;
  int                        tx_idle_pct = 0;
  int                        rx_idle_pct = 0;
  logic                      hold_armed = 1'b0;
  logic                      hold_done = 1'b0;
  int                        hold_left = 0;

  // Shadow copy of the block state
  logic [MAG_W-1:0]   price_hist[0:MAX_WINDOW-1];
  logic [RING_AW-1:0] hist_slot;
  logic [SLOW_W-1:0]  hist_count;
  logic [SUM_W-1:0]   fast_total;
  logic [SUM_W-1:0]   slow_total;
  logic [FAST_W-1:0]  fast_len_m;
  logic [SLOW_W-1:0]  slow_len_m;
  logic [DBAND_W-1:0] band_m;

  longint walk_level;
  int     walk_trend;

  moving_average_crossover_deadband_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_price         (in_price),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_decision     (out_decision),
    .out_config_error (out_config_error),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_window_model();
    hist_slot  = '0;
    hist_count = '0;
    fast_total = '0;
    slow_total = '0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FAST_LEN: begin
        fast_len_m = data[FAST_W-1:0];
        clear_window_model();
      end
      REG_SLOW_LEN: begin
        slow_len_m = data[SLOW_W-1:0];
        clear_window_model();
      end
      REG_DEADBAND: band_m = data[DBAND_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow window by one price and work out the resulting signal.
  function automatic signal_t predict_signal(logic signed [PRICE_W-1:0] price);
    logic [63:0]        lhs;
    logic [63:0]        rhs;
    logic [63:0]        margin;
    logic [RING_AW-1:0] old_slot;
    signal_t            sig;
    sig.decision     = DEC_HOLD;
    sig.config_error = 1'b0;
    if (fast_len_m == 0 || slow_len_m > MAX_WINDOW || fast_len_m >= slow_len_m) begin
      sig.config_error = 1'b1;
      return sig;
    end
    if (price <= 0) return sig;
    if (hist_count >= fast_len_m) begin
      old_slot = hist_slot - fast_len_m;
      fast_total -= SUM_W'(price_hist[old_slot]);
    end
    if (hist_count >= slow_len_m) begin
      old_slot = hist_slot - slow_len_m[RING_AW-1:0];
      slow_total -= SUM_W'(price_hist[old_slot]);
    end
    fast_total += SUM_W'(price[MAG_W-1:0]);
    slow_total += SUM_W'(price[MAG_W-1:0]);
    price_hist[hist_slot] = price[MAG_W-1:0];
    hist_slot++;
    if (hist_count < slow_len_m) hist_count++;
    if (hist_count < slow_len_m) return sig;
    margin = 64'(band_m) * 64'(fast_len_m) * 64'(slow_len_m);
    lhs    = 64'(fast_total) * 64'(slow_len_m);
    rhs    = 64'(slow_total) * 64'(fast_len_m);
    if (lhs > rhs + margin) sig.decision = DEC_BUY;
    else if (lhs + margin < rhs) sig.decision = DEC_SELL;
    return sig;
  endfunction

  // Mostly a trending random walk, with some nonpositive and full-range prices mixed in.
  function automatic logic signed [PRICE_W-1:0] next_price(int spread);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 7) return $urandom | 32'h8000_0000;
    if (roll < 10) return ($urandom & 32'h7FFF_FFFF) | 32'h1;
    if ($urandom_range(19) == 0) walk_trend = int'($urandom_range(spread)) - spread / 2;
    walk_level += walk_trend + int'($urandom_range(2 * spread)) - spread;
    if (walk_level < 1) walk_level = 1;
    if (walk_level > 64'sd2147483647) walk_level = 64'sd2147483647;
    return walk_level[PRICE_W-1:0];
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_register(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (price_queue.size() != 0 || in_valid || expected_signals.size() != 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic run_phase(int fast_len, int slow_len, int band, int n_items,
                           int level, int spread, int tx_pct, int rx_pct);
    wait_idle();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    // Random junk above the length fields must be dropped by the block
    write_reg(REG_FAST_LEN, (CFG_DATA_W'($urandom) << FAST_W) | CFG_DATA_W'(fast_len));
    write_reg(REG_SLOW_LEN, (CFG_DATA_W'($urandom) << SLOW_W) | CFG_DATA_W'(slow_len));
    write_reg(REG_DEADBAND, CFG_DATA_W'(band));
    @(negedge clk);
    walk_level = level;
    walk_trend = 0;
    repeat (n_items) price_queue.push_back(next_price(spread));
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_signals.push_back(predict_signal(in_price));
      if (in_valid && !in_ready) begin
        // hold the transaction until it is taken
      end else if (price_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_price <= price_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    signal_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_signals.size() == 0) begin
        flag_mismatch("result transaction with nothing outstanding");
      end else begin
        want = expected_signals.pop_front();
        if (out_decision !== want.decision)
          flag_mismatch($sformatf("decision %0d, wanted %0d", out_decision, want.decision));
        if (out_config_error !== want.config_error)
          flag_mismatch($sformatf("config_error %0b, wanted %0b",
                                  out_config_error, want.config_error));
      end
    end
  end

  initial begin
    int f7;
    int s7;
    fast_len_m = 6'd2;
    slow_len_m = 7'd3;
    band_m     = '0;
    clear_window_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill, buy, sell, ignored prices, extremes at the reset lengths
    tx_idle_pct = 19;
    rx_idle_pct = 59;
    @(negedge clk);
    price_queue = '{32'sd1, 32'sd2, 32'sd3, 32'sd3, 32'sd3, 32'sd0, -32'sd1,
                    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'sd1, 32'sd1, 32'sd2};
    wait_idle();
    // Deadband keeps the window
    write_reg(REG_DEADBAND, 31'd5);
    @(negedge clk);
    price_queue = '{32'sd10, 32'sd10, 32'sd10, 32'sd20};
    wait_idle();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    price_queue.push_back(32'sd30);
    wait_idle();
    // Unusable lengths
    write_reg(REG_FAST_LEN, 31'd0);
    @(negedge clk);
    price_queue = '{32'sd100, 32'sd0};
    wait_idle();
    write_reg(REG_FAST_LEN, 31'd5);
    write_reg(REG_SLOW_LEN, 31'd5);
    @(negedge clk);
    price_queue.push_back(32'sd100);
    wait_idle();
    write_reg(REG_SLOW_LEN, 31'd127);
    @(negedge clk);
    price_queue.push_back(32'sd100);
    wait_idle();
    write_reg(REG_SLOW_LEN, 31'd65);
    @(negedge clk);
    price_queue.push_back(32'sd100);

    // Random phases
    run_phase(2, 3, 0, 140, 5000, 40, 19, 59);
    run_phase(1, 2, $urandom_range(20), 130, 200, 5, 19, 59);
    run_phase(5, 20, $urandom_range(30), 120, 1_000_000, 60, 19, 59);
    run_phase(63, 64, 0, 150, 2_147_400_000, 300, 59, 19);
    run_phase(10, 40, 2147483647, 110, 80_000, 500, 59, 19);
    run_phase(3, 7, $urandom_range(100), 130, 30_000, 200, 59, 19);
    f7 = $urandom_range(1, 30);
    s7 = $urandom_range(f7 + 1, MAX_WINDOW);
    run_phase(f7, s7, $urandom_range(50), 140, 10_000, 80, 0, 0);
    // Stall the result side while the sender keeps offering
    hold_armed <= 1'b1;
    run_phase(40, 20, $urandom_range(1000), 30, 500, 20, 0, 0);
    run_phase(8, 16, 50, 150, 2_000_000, 400, 0, 0);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("moving_average_crossover_deadband_core test passed");
    end else begin
      $display("moving_average_crossover_deadband_core test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("moving_average_crossover_deadband_core test failed");
    $finish;
  end

endmodule
